/* src/lsf_pkg.sv */
// lsf_pkg: shared types and constants for the length/sum framer
package lsf_pkg;

    localparam int IN_DATA_W   = 40;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam int LEN_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IN_USER_W-1:0] KIND_START = 2'd0;
    localparam logic [IN_USER_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [IN_USER_W-1:0] KIND_END   = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h2A;

    typedef enum logic [1:0] {
        OP_HDR,
        OP_DATA,
        OP_TRL
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [LEN_W-1:0] word;
    } cmd_t;

endpackage

/* src/lsf_front.sv */
// lsf_front: accepts input beats, keeps the running sum, issues byte commands
module lsf_front
    import lsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // payload_length, data_byte
    input  logic [IN_USER_W-1:0] s_axis_tuser,   // kind
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_wdata
);

    logic [LEN_W-1:0]  sum_reg;
    logic [LEN_W-1:0]  sum_next;
    logic              accept;
    logic [LEN_W-1:0]  len_in;
    logic [BYTE_W-1:0] byte_in;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign len_in        = s_axis_tdata[LEN_W-1:0];
    assign byte_in       = s_axis_tdata[LEN_W+BYTE_W-1:LEN_W];

    always_comb begin
        sum_next     = sum_reg;
        q_push       = 1'b0;
        q_wdata.op   = OP_DATA;
        q_wdata.word = {{(LEN_W-BYTE_W){1'b0}}, byte_in};
        unique case (s_axis_tuser)
            KIND_START: begin
                q_push       = accept;
                q_wdata.op   = OP_HDR;
                q_wdata.word = len_in;
                if (accept) begin
                    sum_next = '0;
                end
            end
            KIND_DATA: begin
                q_push = accept;
                if (accept) begin
                    sum_next = sum_reg + {{(LEN_W-BYTE_W){1'b0}}, byte_in};
                end
            end
            KIND_END: begin
                q_push       = accept;
                q_wdata.op   = OP_TRL;
                q_wdata.word = sum_reg;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

endmodule

/* src/lsf_queue.sv */
// lsf_queue: short command fifo between the front and back parts
module lsf_queue
    import lsf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/lsf_back.sv */
// lsf_back: serializes queued commands into output byte beats
module lsf_back
    import lsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  cmd_t                  q_head,
    output logic                  q_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_byte
    output logic                  m_axis_tlast
);

    logic [2:0]            idx_reg;
    logic [2:0]            idx_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [OUT_DATA_W-1:0] data_reg;
    logic                  last_reg;
    logic                  load;
    logic [OUT_DATA_W-1:0] cur_byte;
    logic                  cur_last;
    logic                  cur_final;
    logic [1:0]            sel;
    logic [2:0]            idx_m1;

    function automatic logic [BYTE_W-1:0] msb_byte(input logic [LEN_W-1:0] w,
                                                    input logic [1:0] k);
        logic [BYTE_W-1:0] b;
        case (k)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    assign load   = (!valid_reg || m_axis_tready) && !q_empty;
    assign idx_m1 = idx_reg - 3'd1;

    always_comb begin
        sel       = idx_reg[1:0];
        cur_byte  = q_head.word[BYTE_W-1:0];
        cur_last  = 1'b0;
        cur_final = 1'b1;
        unique case (q_head.op)
            OP_HDR: begin
                sel       = idx_m1[1:0];
                cur_byte  = (idx_reg == 3'd0) ? SYNC_BYTE : msb_byte(q_head.word, sel);
                cur_final = (idx_reg == 3'd4);
            end
            OP_TRL: begin
                cur_byte  = msb_byte(q_head.word, sel);
                cur_final = (idx_reg == 3'd3);
                cur_last  = cur_final;
            end
            OP_DATA: begin
                cur_final = 1'b1;
            end
            default: begin
                cur_final = 1'b1;
            end
        endcase
    end

    always_comb begin
        q_pop      = load && cur_final;
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_axis_tready;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = cur_final ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= cur_byte;
            last_reg <= cur_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

/* src/length_sum_framer_top.sv */
// length_sum_framer_top: frame builder with length header and additive checksum trailer
// Each input beat is classified by the front part and queued as one command; the back part
// turns commands into output bytes. A payload beat yields one output byte, so payload
// streams at one byte per cycle while the output is not stalled. A start beat yields five
// output bytes (sync '*' and the length, msb first) and an end beat four (the wrapping
// 32-bit byte sum, msb first, the last one flagged by tlast); the serializer sends these
// one byte at a time, while the four-entry command queue keeps taking input beats until it
// fills. Kind 3 is dropped. The output is registered; the first byte of an input beat
// passes through the command queue and the output register before it is offered.
module length_sum_framer_top
    import lsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // payload_length, data_byte
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_byte
    output logic                  m_axis_tlast    // last
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_wdata;
    cmd_t q_head;

    lsf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    lsf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    lsf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* src/lsf_checker.sv */
// lsf_checker: port-level assertions for the framer, bound to the top level
module lsf_checker
    import lsf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [IN_USER_W-1:0]  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // output idle right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a full queue always has a beat on offer
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output beat pending");

    // offered output beat is fully defined
    a_out_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tlast}))
        else $error("output beat carries unknown bits");

    // stalled input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("input beat changed while stalled");

endmodule

bind length_sum_framer_top lsf_checker u_lsf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/length_sum_framer_top_test.sv */
// length_sum_framer_top_test: self-checking stream testbench for the length/sum framer
`timescale 1ns / 100ps

module length_sum_framer_top_test;
    import lsf_pkg::*;

    localparam logic [IN_USER_W-1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 330;
    localparam int PAUSE_AT = 180;

    typedef struct {
        logic [IN_USER_W-1:0] kind;
        logic [LEN_W-1:0]     length;
        logic [BYTE_W-1:0]    data;
    } upload_item_t;

    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } framed_byte_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    upload_item_t pending_items[$];
    framed_byte_t bytes_due[$];
    logic [LEN_W-1:0] byte_sum = '0;

    int cycles = 0;
    int items_taken = 0;
    int items_queued = 0;
    int frames_started = 0;
    int payload_bytes = 0;
    int spare_beats = 0;
    int bytes_checked = 0;
    int mismatches = 0;

    wire steady = (items_taken >= 150) && (items_taken < 230);

    length_sum_framer_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // payload_length, data_byte
        .s_axis_tuser  (s_axis_tuser),   // kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_byte
        .m_axis_tlast  (m_axis_tlast)    // last
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cycles, bytes_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_due(input logic [BYTE_W-1:0] b, input logic last);
        framed_byte_t fb;
        fb.out_byte = b;
        fb.last = last;
        bytes_due.push_back(fb);
    endtask

    task automatic push_word_due(input logic [LEN_W-1:0] word, input logic mark_last);
        for (int i = 0; i < 4; i++)
            push_due(word[LEN_W-1-8*i -: BYTE_W], mark_last && (i == 3));
    endtask

    task automatic frame_predict(input upload_item_t it);
        case (it.kind)
            KIND_START: begin
                byte_sum = '0;
                frames_started++;
                push_due(SYNC_BYTE, 1'b0);
                push_word_due(it.length, 1'b0);
            end
            KIND_DATA: begin
                byte_sum = byte_sum + LEN_W'(it.data);
                payload_bytes++;
                push_due(it.data, 1'b0);
            end
            KIND_END: begin
                push_word_due(byte_sum, 1'b1);
            end
            default: begin
                spare_beats++;
            end
        endcase
    endtask

    // input side
    always @(posedge aclk) begin : drive_proc
        upload_item_t nxt;
        logic hold;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            hold = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                frame_predict(pending_items.pop_front());
                items_taken++;
            end
            if (!hold) begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
                    nxt = pending_items[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nxt.data, nxt.length};
                    s_axis_tuser  <= nxt.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom});
                    s_axis_tuser  <= IN_USER_W'($urandom);
                end
            end
        end
    end

    // output side
    always @(posedge aclk) begin : check_proc
        framed_byte_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                bytes_checked++;
                if (bytes_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected beat byte=%02h last=%b",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end else begin
                    want = bytes_due.pop_front();
                    if (want.out_byte !== m_axis_tdata || want.last !== m_axis_tlast) begin
                        if (mismatches < 10)
                            $display("%0t: beat %0d byte exp %02h got %02h, last exp %b got %b",
                                     $realtime, bytes_checked, want.out_byte, m_axis_tdata,
                                     want.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 28);
        end
    end

    task automatic push_item(input logic [IN_USER_W-1:0] kind, input logic [LEN_W-1:0] length,
                             input logic [BYTE_W-1:0] data);
        upload_item_t it;
        it.kind = kind;
        it.length = length;
        it.data = data;
        pending_items.push_back(it);
        if (kind != KIND_SPARE)
            items_queued++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || bytes_due.size() != 0)
            @(negedge aclk);
    endtask

    initial begin : stimulus_proc
        int n;
        logic [LEN_W-1:0] len;
        bit paused;
        paused = 0;

        // payload and end before any start, spare kind, repeated end
        push_item(KIND_DATA, $urandom, 8'h5A);
        push_item(KIND_END, $urandom, BYTE_W'($urandom));
        push_item(KIND_SPARE, 32'hFFFF_FFFF, 8'hFF);
        push_item(KIND_START, 32'h0000_0000, 8'hFF);
        push_item(KIND_END, 32'hFFFF_FFFF, 8'hFF);
        push_item(KIND_START, 32'hFFFF_FFFF, 8'h00);
        push_item(KIND_DATA, 32'hFFFF_FFFF, 8'hFF);
        push_item(KIND_DATA, 32'h0000_0000, 8'hFF);
        push_item(KIND_DATA, $urandom, 8'h00);
        push_item(KIND_SPARE, 32'h0000_0000, 8'h00);
        push_item(KIND_DATA, $urandom, 8'h80);
        push_item(KIND_END, 32'h0000_0000, 8'h00);
        push_item(KIND_END, $urandom, BYTE_W'($urandom));
        push_item(KIND_START, 32'hA5A5_5A5A, BYTE_W'($urandom));
        push_item(KIND_DATA, $urandom, 8'h01);
        push_item(KIND_START, 32'h0000_0003, BYTE_W'($urandom));
        push_item(KIND_DATA, $urandom, 8'hFE);
        push_item(KIND_DATA, $urandom, 8'h7F);
        push_item(KIND_DATA, $urandom, 8'h01);
        push_item(KIND_END, $urandom, BYTE_W'($urandom));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        items_queued = 0;
        while (items_queued < RANDOM_ITEMS) begin
            if (!paused && items_queued >= PAUSE_AT) begin
                paused = 1;
                wait_drained();
            end
            if ($urandom_range(99) < 80) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8);
                len = ($urandom_range(3) == 0) ? LEN_W'($urandom) : LEN_W'(n);
                push_item(KIND_START, len, BYTE_W'($urandom));
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(15) == 0)
                        push_item(KIND_SPARE, $urandom, BYTE_W'($urandom));
                    push_item(KIND_DATA, $urandom, pick_byte());
                end
                push_item(KIND_END, $urandom, BYTE_W'($urandom));
                if ($urandom_range(7) == 0)
                    push_item(KIND_END, $urandom, BYTE_W'($urandom));
            end else begin
                case ($urandom_range(2))
                    0:       push_item(KIND_DATA, $urandom, pick_byte());
                    1:       push_item(KIND_END, $urandom, BYTE_W'($urandom));
                    default: push_item(KIND_SPARE, $urandom, BYTE_W'($urandom));
                endcase
            end
        end

        wait_drained();
        repeat (16) @(negedge aclk);

        $display("%0d beats in: %0d frames opened, %0d payload bytes, %0d kind-3 beats dropped",
                 items_taken, frames_started, payload_bytes, spare_beats);
        $display("%0d output bytes checked, %0d mismatches, %0d left due",
                 bytes_checked, mismatches, bytes_due.size());
        if (mismatches == 0 && bytes_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* length_sum_framer_top.f */
src/lsf_pkg.sv
src/lsf_front.sv
src/lsf_queue.sv
src/lsf_back.sv
src/length_sum_framer_top.sv
src/lsf_checker.sv
tb/length_sum_framer_top_test.sv
